// File: rtl/core/bcdc_pkg.sv
// shared types, register map, codes and bcd helpers for the calendar clock
package bcdc_pkg;

    localparam int NUM_REGS_DEF = 24;

    // item kinds carried on tuser
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // register map (dense word index)
    localparam int RG_SECOND    = 0;
    localparam int RG_MINUTE    = 1;
    localparam int RG_HOUR      = 2;
    localparam int RG_DAY       = 3;
    localparam int RG_MONTH     = 4;
    localparam int RG_YEAR      = 5;
    localparam int RG_CTRL      = 13;
    localparam int RG_INTERRUPT = 15;
    localparam int NUM_TIME     = 6;

    localparam int CTRL_RUN_BIT  = 0;
    localparam int INT_TIMER_BIT = 2;

    localparam logic [3:0] SEC_TENS_MASK   = 4'h7;
    localparam logic [3:0] HOUR_TENS_MASK  = 4'h3;
    localparam logic [3:0] MONTH_TENS_MASK = 4'h1;
    localparam logic [3:0] YEAR_TENS_MASK  = 4'hf;

    // low bytes of second..year, indexed by RG_*
    typedef logic [NUM_TIME-1:0][7:0] bcdc_time_t;

    typedef struct packed {
        logic [NUM_TIME-1:0] wen;
        bcdc_time_t          val;
    } bcdc_upd_t;

    // tens digit masked, then tens*10 + ones (ones may exceed 9)
    function automatic logic [7:0] from_bcd(input logic [7:0] r, input logic [3:0] mask);
        logic [7:0] tens;
        tens = {4'b0, r[7:4] & mask};
        return 8'(tens * 8'd10) + {4'b0, r[3:0]};
    endfunction

    // value is at most 99; divide by ten through a reciprocal multiply
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        ones = v - 7'(tens * 7'd10);
        return {tens, ones[3:0]};
    endfunction

    // february fixed at 28, a bad month has length zero
    function automatic logic [5:0] month_days(input logic [7:0] m);
        logic [5:0] d;
        case (m)
            8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: d = 6'd31;
            8'd4, 8'd6, 8'd9, 8'd11:                    d = 6'd30;
            8'd2:                                       d = 6'd28;
            default:                                    d = 6'd0;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/core/bcdc_tick.sv
// one-second bcd carry cascade over second, minute, hour, day, month, year
module bcdc_tick (
    input  logic               advance,
    input  bcdc_pkg::bcdc_time_t cur,
    output bcdc_pkg::bcdc_upd_t  upd
);
    import bcdc_pkg::*;

    logic [7:0] sec_v, min_v, hour_v, day_v, mon_v, year_v;
    logic [5:0] lim;
    logic       c_sec, c_min, c_hour, c_day, c_mon;

    always_comb
    begin
        sec_v  = from_bcd(cur[RG_SECOND], SEC_TENS_MASK);
        min_v  = from_bcd(cur[RG_MINUTE], SEC_TENS_MASK);
        hour_v = from_bcd(cur[RG_HOUR], HOUR_TENS_MASK);
        day_v  = from_bcd(cur[RG_DAY], HOUR_TENS_MASK);
        mon_v  = from_bcd(cur[RG_MONTH], MONTH_TENS_MASK);
        year_v = from_bcd(cur[RG_YEAR], YEAR_TENS_MASK);
        lim    = month_days(mon_v);

        c_sec  = advance && (sec_v >= 8'd59);
        c_min  = c_sec && (min_v >= 8'd59);
        c_hour = c_min && (hour_v >= 8'd23);
        c_day  = c_hour && (day_v >= {2'b0, lim});
        c_mon  = c_day && (mon_v >= 8'd12);

        upd.wen[RG_SECOND] = advance;
        upd.wen[RG_MINUTE] = c_sec;
        upd.wen[RG_HOUR]   = c_min;
        upd.wen[RG_DAY]    = c_hour;
        upd.wen[RG_MONTH]  = c_day;
        upd.wen[RG_YEAR]   = c_mon;

        upd.val[RG_SECOND] = (sec_v >= 8'd59) ? 8'd0 : to_bcd(7'(sec_v + 8'd1));
        upd.val[RG_MINUTE] = (min_v >= 8'd59) ? 8'd0 : to_bcd(7'(min_v + 8'd1));
        upd.val[RG_HOUR]   = (hour_v >= 8'd23) ? 8'd0 : to_bcd(7'(hour_v + 8'd1));
        upd.val[RG_DAY]    = (day_v >= {2'b0, lim}) ? to_bcd(7'd1)
                                                    : to_bcd(7'(day_v + 8'd1));
        upd.val[RG_MONTH]  = (mon_v >= 8'd12) ? to_bcd(7'd1) : to_bcd(7'(mon_v + 8'd1));
        upd.val[RG_YEAR]   = (year_v >= 8'd99) ? 8'd0 : to_bcd(7'(year_v + 8'd1));
    end

endmodule

// File: rtl/core/bcd_calendar_clock_registers.sv
// top level of the bcd real-time clock and calendar register bank
//
// usage
//   slave stream carries one word per event: a one-second tick, a register
//   read or a register write, selected by tuser (0 tick, 1 read, 2 write)
//   master stream returns exactly one word per accepted input word, in order:
//   read data in tdata, irq and bad_index flags in tuser
//   registers 0..5 hold second, minute, hour, day, month, year as bcd;
//   ctrl bit 0 runs the clock, interrupt bit 2 enables irq on a running tick
// pipeline and throughput
//   each accepted word passes the input register, then the result register;
//   one word per cycle sustained while m_axis_tready holds, since the bank
//   and the carry cascade update in the cycle between the two registers
// reset
//   the register bank clears to zero, both pipeline stages empty; tready stays
//   low until the first cycle after reset is released
// stall
//   a held result keeps tdata/tuser stable; the input register still takes
//   one more word, then tready drops until the result is taken
module bcd_calendar_clock_registers #(
    parameter int NUM_REGS = bcdc_pkg::NUM_REGS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // reg_index[4:0], write_data[36:5], zero[39:37]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // read_data[31:0]
    output logic [1:0]  m_axis_tuser   // irq[0], bad_index[1]
);
    import bcdc_pkg::*;

    // register bank, one flop word per register
    logic [31:0] rf_reg  [NUM_REGS];
    logic [31:0] rf_next [NUM_REGS];

    // input stage
    logic        ready_en_reg;
    logic        s1_valid_reg;
    logic [1:0]  s1_mode_reg;
    logic [4:0]  s1_idx_reg;
    logic [31:0] s1_data_reg;

    // result stage
    logic        out_valid_reg;
    logic [31:0] out_data_reg, out_data_next;
    logic        out_irq_reg, out_irq_next;
    logic        out_bad_reg, out_bad_next;

    logic        s1_adv;
    logic        in_take;
    logic        idx_ok;
    logic        run;
    bcdc_time_t  cur_time;
    bcdc_upd_t   upd;

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = ready_en_reg && (!s1_valid_reg || s1_adv);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = {out_bad_reg, out_irq_reg};

    assign idx_ok = {1'b0, s1_idx_reg} < 6'(NUM_REGS);
    assign run    = rf_reg[RG_CTRL][CTRL_RUN_BIT];

    always_comb
    begin
        for (int i = 0; i < NUM_TIME; i++)
        begin
            cur_time[i] = rf_reg[i][7:0];
        end
    end

    bcdc_tick u_tick (
        .advance (s1_mode_reg == MODE_TICK && run),
        .cur     (cur_time),
        .upd     (upd)
    );

    // next bank contents and result word for the item in the input stage
    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            rf_next[i] = rf_reg[i];
        end
        out_data_next = 32'd0;
        out_irq_next  = 1'b0;
        out_bad_next  = 1'b0;

        case (s1_mode_reg)
            MODE_TICK:
            begin
                for (int i = 0; i < NUM_TIME; i++)
                begin
                    if (upd.wen[i])
                    begin
                        rf_next[i] = {24'd0, upd.val[i]};
                    end
                end
                out_irq_next = run && rf_reg[RG_INTERRUPT][INT_TIMER_BIT];
            end
            MODE_READ:
            begin
                out_bad_next = !idx_ok;
                for (int i = 0; i < NUM_REGS; i++)
                begin
                    if (s1_idx_reg == 5'(i))
                    begin
                        out_data_next = rf_reg[i];
                    end
                end
            end
            MODE_WRITE:
            begin
                out_bad_next = !idx_ok;
                for (int i = 0; i < NUM_REGS; i++)
                begin
                    if (s1_idx_reg == 5'(i))
                    begin
                        rf_next[i] = s1_data_reg;
                    end
                end
            end
            default:
            begin
                out_data_next = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                rf_reg[i] <= 32'd0;
            end
            ready_en_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ready_en_reg <= 1'b1;
            if (s1_adv)
            begin
                for (int i = 0; i < NUM_REGS; i++)
                begin
                    rf_reg[i] <= rf_next[i];
                end
            end
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg <= s_axis_tuser;
            s1_idx_reg  <= s_axis_tdata[4:0];
            s1_data_reg <= s_axis_tdata[36:5];
        end
        if (s1_adv)
        begin
            out_data_reg <= out_data_next;
            out_irq_reg  <= out_irq_next;
            out_bad_reg  <= out_bad_next;
        end
    end

endmodule

// File: rtl/core/bcdc_checker.sv
// port-level checks for the calendar clock, bound to the top level
module bcdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // irq comes only from ticks, bad_index only from accesses
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("irq and bad_index set together");

    a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))
        else $error("tick word carries read data");

    a_bad_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == 32'd0))
        else $error("bad index word carries read data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result word changed");

endmodule

bind bcd_calendar_clock_registers bcdc_checker u_bcdc_checker (.*);
